// ----- hdl/lsw_pkg.sv -----
`timescale 1ns / 1ps
package lsw_pkg;
    localparam int NEURONS_DEF   = 8;
    localparam int INPUTS_DEF    = 784;
    localparam int WORD_BITS_DEF = 16;
    localparam int POT_W = 24;
    localparam int WGT_W = 16;

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_SPIKE = 2'd1,
        CMD_START = 2'd2,
        CMD_READ  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        REG_THRESH = 3'd0,
        REG_RESETP = 3'd1,
        REG_REST   = 3'd2,
        REG_MIN    = 3'd3,
        REG_LEAK   = 3'd4,
        REG_REFR   = 3'd5
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACCUM,
        ST_UPDATE,
        ST_FIRE,
        ST_REPORT,
        ST_READ
    } state_t;

    function automatic logic signed [POT_W-1:0] sat24(input logic signed [POT_W+1:0] v);
        logic signed [POT_W+1:0] hi;
        logic signed [POT_W+1:0] lo;
        begin
            hi = 26'sd8388607;
            lo = -26'sd8388608;
            if (v > hi)
                sat24 = 24'sh7FFFFF;
            else if (v < lo)
                sat24 = 24'sh800000;
            else
                sat24 = v[POT_W-1:0];
        end
    endfunction
endpackage

// ----- hdl/lif_snn_wta_layer.sv -----
`timescale 1ns / 1ps
// A spike word issues NEURONS weight reads for each spiking pixel within the word and then
// waits for the registered read data; the weight RAM port is the limit (one weight per cycle).
// A word with no set bit in range issues no reads. End of step then updates and fires each
// neuron in turn and waits out any stalled earlier result beat. The input stalls all the while.
// Count readout gives min(NEURONS,8) beats, one per cycle as the consumer takes them.
// Reset clears all control and neuron state, presets config; weights undefined until loaded.
module lif_snn_wta_layer #(
    parameter int NEURONS   = lsw_pkg::NEURONS_DEF,
    parameter int INPUTS    = lsw_pkg::INPUTS_DEF,
    parameter int WORD_BITS = lsw_pkg::WORD_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  cmd,
    input  logic [2:0]  neuron_index,
    input  logic [9:0]  pixel_index,
    input  logic signed [15:0] weight_value,
    input  logic [15:0] spike_word,
    input  logic        end_of_step,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        result_kind,
    output logic [7:0]  fired_mask,
    output logic        winner_valid,
    output logic [2:0]  winner_index,
    output logic [2:0]  count_neuron,
    output logic [7:0]  spike_total,
    output logic        last_result
);
    import lsw_pkg::*;

    localparam int NW = (NEURONS > 1) ? $clog2(NEURONS) : 1;
    localparam int NC = $clog2(NEURONS + 1);
    localparam int BW = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
    localparam int DEPTH = NEURONS * INPUTS;
    localparam int AW = $clog2(DEPTH);
    localparam int PW = $clog2(INPUTS + WORD_BITS + 1);
    localparam int REPORTED = (NEURONS < 8) ? NEURONS : 8;

    // configuration
    logic signed [23:0] thr_reg, rstp_reg, rest_reg, minp_reg;
    logic [15:0] leak_reg;
    logic [3:0]  refr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg  <= 24'sd614400;
            rstp_reg <= '0;
            rest_reg <= '0;
            minp_reg <= -24'sd4096;
            leak_reg <= 16'd2048;
            refr_reg <= 4'd4;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_THRESH: thr_reg  <= cfg_data;
                REG_RESETP: rstp_reg <= cfg_data;
                REG_REST:   rest_reg <= cfg_data;
                REG_MIN:    minp_reg <= cfg_data;
                REG_LEAK:   leak_reg <= cfg_data[15:0];
                REG_REFR:   refr_reg <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // neuron state, one row per neuron
    logic signed [23:0] pot_reg [NEURONS];
    logic signed [23:0] sum_reg [NEURONS];
    logic signed [23:0] act_reg [NEURONS];
    logic [3:0]         refl_reg [NEURONS];
    logic [7:0]         cnt_reg [NEURONS];
    logic               inh_reg;

    state_t state_reg, state_next;
    logic [WORD_BITS-1:0] bits_reg;
    logic [PW-1:0]        base_reg;
    logic                 eos_reg;
    logic [BW-1:0]        bit_reg;
    logic [NW-1:0]        nrd_reg;       // neuron being read
    logic                 issue_reg;     // still issuing reads
    logic                 v1_reg;        // read data valid this cycle
    logic [NW-1:0]        n1_reg;
    logic [NC-1:0]        idx_reg;
    logic [NW-1:0]        best_reg;
    logic [7:0]           mask_reg;
    logic                 wv_reg;
    logic [2:0]           wi_reg;
    logic [2:0]           rd_reg;

    // output register
    logic       ov_reg, okind_reg, owv_reg, olast_reg;
    logic [7:0] omask_reg, otot_reg;
    logic [2:0] owi_reg, ocn_reg;

    logic in_acc, out_take;
    assign in_stall = (state_reg != ST_IDLE);
    assign in_acc   = in_valid && !in_stall;
    assign out_take = ov_reg && !out_stall;

    // find current bit: next set bit in range from bit_reg
    logic [WORD_BITS-1:0] live;
    always_comb
    begin
        for (int b = 0; b < WORD_BITS; b++)
            live[b] = bits_reg[b] && (b >= int'(bit_reg))
                      && ((int'(base_reg) + b) < INPUTS);
    end
    logic            have_bit;
    logic [BW-1:0]   cur_bit;
    always_comb
    begin
        have_bit = 1'b0;
        cur_bit  = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--)
            if (live[b])
            begin
                have_bit = 1'b1;
                cur_bit  = BW'(b);
            end
    end

    // weight memory
    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [15:0]   ram_rdata;
    logic [AW+PW-1:0] pix_full;
    assign pix_full  = (AW+PW)'(base_reg) + (AW+PW)'(cur_bit);
    assign ram_raddr = AW'((AW+PW)'(nrd_reg) * (AW+PW)'(INPUTS) + pix_full);
    assign ram_we    = in_acc && (cmd == CMD_LOAD) && (int'(neuron_index) < NEURONS)
                       && (int'(pixel_index) < INPUTS);
    assign ram_waddr = AW'((AW+PW)'(neuron_index) * (AW+PW)'(INPUTS)
                           + (AW+PW)'(pixel_index));

    lsw_ram #(.WIDTH(WGT_W), .DEPTH(DEPTH)) u_wram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (weight_value),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (in_acc)
                begin
                    if (cmd == CMD_SPIKE)
                        state_next = ST_ACCUM;
                    else if (cmd == CMD_READ)
                        state_next = ST_READ;
                end
            ST_ACCUM:
                if (!issue_reg && !v1_reg && !have_bit)
                    state_next = eos_reg ? ST_UPDATE : ST_IDLE;
            ST_UPDATE:
                if (int'(idx_reg) == NEURONS)
                    state_next = ST_FIRE;
            ST_FIRE:
                if (int'(idx_reg) == NEURONS)
                    state_next = ST_REPORT;
            ST_REPORT:
                if (!ov_reg || out_take)
                    state_next = ST_IDLE;
            ST_READ:
                if ((!ov_reg || out_take) && int'(rd_reg) == REPORTED - 1)
                    state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs of the controller: read issue is active while a bit is pending, and a result
    // beat is loaded in report or read whenever the output register is free or being emptied
    logic issue_now, out_load;
    always_comb
    begin
        issue_now = (state_reg == ST_ACCUM) && have_bit;
        out_load  = ((state_reg == ST_REPORT) || (state_reg == ST_READ))
                    && (!ov_reg || out_take);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    logic signed [23:0] best_pot;
    assign best_pot = act_reg[best_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issue_reg <= 1'b0;
            v1_reg    <= 1'b0;
            n1_reg    <= '0;
            nrd_reg   <= '0;
            bit_reg   <= '0;
            bits_reg  <= '0;
            base_reg  <= '0;
            eos_reg   <= 1'b0;
            idx_reg   <= '0;
            best_reg  <= '0;
            mask_reg  <= '0;
            wv_reg    <= 1'b0;
            wi_reg    <= '0;
            inh_reg   <= 1'b0;
            ov_reg    <= 1'b0;
            okind_reg <= 1'b0;
            omask_reg <= '0;
            owv_reg   <= 1'b0;
            owi_reg   <= '0;
            ocn_reg   <= '0;
            otot_reg  <= '0;
            olast_reg <= 1'b0;
            rd_reg    <= '0;
            for (int j = 0; j < NEURONS; j++)
            begin
                pot_reg[j]  <= '0;
                sum_reg[j]  <= '0;
                act_reg[j]  <= '0;
                refl_reg[j] <= '0;
                cnt_reg[j]  <= '0;
            end
        end
        else
        begin
            if (out_load)
                ov_reg <= 1'b1;
            else if (out_take)
                ov_reg <= 1'b0;
            v1_reg <= issue_now;
            n1_reg <= nrd_reg;
            if (v1_reg)
                sum_reg[n1_reg] <= sat24(26'(sum_reg[n1_reg]) + 26'(signed'(ram_rdata)));
            issue_reg <= issue_now;

            unique case (state_reg)
                ST_IDLE:
                    if (in_acc)
                    begin
                        bits_reg <= WORD_BITS'(spike_word);
                        base_reg <= PW'(pixel_index);
                        eos_reg  <= end_of_step;
                        bit_reg  <= '0;
                        nrd_reg  <= '0;
                        idx_reg  <= '0;
                        rd_reg   <= '0;
                        mask_reg <= '0;
                        wv_reg   <= 1'b0;
                        wi_reg   <= '0;
                        best_reg <= '0;
                        if (cmd == CMD_START)
                        begin
                            inh_reg <= 1'b0;
                            for (int j = 0; j < NEURONS; j++)
                            begin
                                pot_reg[j]  <= '0;
                                sum_reg[j]  <= '0;
                                act_reg[j]  <= '0;
                                refl_reg[j] <= '0;
                                cnt_reg[j]  <= '0;
                            end
                        end
                    end
                ST_ACCUM:
                    if (issue_now)
                    begin
                        if (int'(nrd_reg) == NEURONS - 1)
                        begin
                            nrd_reg <= '0;
                            bits_reg[cur_bit] <= 1'b0;
                        end
                        else
                            nrd_reg <= nrd_reg + 1'b1;
                    end
                ST_UPDATE:
                    // one neuron per cycle; running maximum over active potentials
                    if (int'(idx_reg) < NEURONS)
                    begin
                        logic signed [23:0] p, a;
                        p = sat24(26'(pot_reg[NW'(idx_reg)]) + 26'(sum_reg[NW'(idx_reg)]));
                        if (p > rest_reg)
                            p = sat24(26'(p) - 26'(leak_reg));
                        a = act_reg[NW'(idx_reg)];
                        if (refl_reg[NW'(idx_reg)] != 0)
                            refl_reg[NW'(idx_reg)] <= refl_reg[NW'(idx_reg)] - 1'b1;
                        else
                        begin
                            pot_reg[NW'(idx_reg)] <= p;
                            act_reg[NW'(idx_reg)] <= p;
                            a = p;
                        end
                        if (idx_reg != 0 && a > best_pot)
                            best_reg <= NW'(idx_reg);
                        idx_reg <= idx_reg + 1'b1;
                    end
                    else
                    begin
                        idx_reg <= '0;
                        if (!inh_reg && best_pot > thr_reg)
                        begin
                            inh_reg <= 1'b1;
                            wv_reg  <= 1'b1;
                            wi_reg  <= 3'(best_reg);
                            for (int j = 0; j < NEURONS; j++)
                                if (NW'(j) != best_reg)
                                    pot_reg[j] <= minp_reg;
                        end
                    end
                ST_FIRE:
                    if (int'(idx_reg) < NEURONS)
                    begin
                        if (pot_reg[NW'(idx_reg)] > thr_reg)
                        begin
                            pot_reg[NW'(idx_reg)] <= rstp_reg;
                            if (cnt_reg[NW'(idx_reg)] != 8'hFF)
                                cnt_reg[NW'(idx_reg)] <= cnt_reg[NW'(idx_reg)] + 1'b1;
                            refl_reg[NW'(idx_reg)] <= refr_reg;
                            if (int'(idx_reg) < 8)
                                mask_reg[3'(idx_reg)] <= 1'b1;
                        end
                        else if (pot_reg[NW'(idx_reg)] < minp_reg)
                            pot_reg[NW'(idx_reg)] <= rest_reg;
                        sum_reg[NW'(idx_reg)] <= '0;
                        idx_reg <= idx_reg + 1'b1;
                    end
                ST_REPORT:
                    if (out_load)
                    begin
                        okind_reg <= 1'b0;
                        omask_reg <= mask_reg;
                        owv_reg   <= wv_reg;
                        owi_reg   <= wi_reg;
                        ocn_reg   <= '0;
                        otot_reg  <= '0;
                        olast_reg <= 1'b1;
                    end
                ST_READ:
                    if (out_load)
                    begin
                        okind_reg <= 1'b1;
                        omask_reg <= '0;
                        owv_reg   <= 1'b0;
                        owi_reg   <= '0;
                        ocn_reg   <= rd_reg;
                        otot_reg  <= cnt_reg[NW'(rd_reg)];
                        olast_reg <= (int'(rd_reg) == REPORTED - 1);
                        rd_reg    <= rd_reg + 1'b1;
                    end
                default: ;
            endcase
        end
    end

    assign out_valid    = ov_reg;
    assign result_kind  = okind_reg;
    assign fired_mask   = omask_reg;
    assign winner_valid = owv_reg;
    assign winner_index = owi_reg;
    assign count_neuron = ocn_reg;
    assign spike_total  = otot_reg;
    assign last_result  = olast_reg;
endmodule

// ----- hdl/lsw_ram.sv -----
`timescale 1ns / 1ps
module lsw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule

// ----- hdl/lsw_checker.sv -----
`timescale 1ns / 1ps
module lsw_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic       result_kind,
    input logic       winner_valid,
    input logic [7:0] fired_mask,
    input logic [2:0] count_neuron,
    input logic       last_result
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result beat dropped while stalled");

    a_rep_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !result_kind |-> last_result && count_neuron == 3'd0)
        else $error("step report malformed");

    a_read_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_kind |-> !winner_valid && fired_mask == 8'd0)
        else $error("readout carries step fields");

    a_rd_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && result_kind && !last_result
        |=> out_valid && result_kind)
        else $error("readout sequence broken");
endmodule

bind lif_snn_wta_layer lsw_checker u_lsw_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .result_kind  (result_kind),
    .winner_valid (winner_valid),
    .fired_mask   (fired_mask),
    .count_neuron (count_neuron),
    .last_result  (last_result)
);
